FILE: rtl/cfl_pkg.sv
// Shared constants and types for the CFL time-step controller.
package cfl_pkg;
    localparam int TIME_FRAC_BITS  = 24;
    localparam int SPEED_FRAC_BITS = 16;
    localparam int W  = 32;
    localparam int FW = 24;
    localparam int TW = 48;
    localparam int DNW = 64;

    typedef enum logic [2:0] {
        CFG_FIXED_STEP   = 3'd0,
        CFG_FRAME_PERIOD = 3'd1,
        CFG_TARGET_CFL   = 3'd2,
        CFG_MIN_STEP     = 3'd3,
        CFG_CELL_SIZE    = 3'd4,
        CFG_SYNC_FRAMES  = 3'd5,
        CFG_SQUARED_SP   = 3'd6,
        CFG_FRAME_LIMIT  = 3'd7
    } t_cfg_idx;

    // request to the serial divider
    typedef struct packed {
        logic             start;
        logic [DNW-1:0]   num;
        logic [W-1:0]     den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DNW-1:0]   quot;
        logic [W-1:0]     rem;
    } t_div_rsp;
endpackage

FILE: rtl/cfl_mul.sv
// Bit-serial 32x32 multiplier, one multiplier bit per cycle.
module cfl_mul
    import cfl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic             o_done,
    output logic [2*W-1:0]   o_prod
);
    logic [W-1:0]   r_b;
    logic [2*W-1:0] r_acc;
    logic [W-1:0]   r_a;
    logic [5:0]     r_cnt;
    logic           r_busy;
    logic           r_done;

    // shift-and-add from the top bit of b down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(W);
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= (r_acc << 1) + (r_b[W-1] ? {{W{1'b0}}, r_a} : '0);
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

FILE: rtl/cfl_div.sv
// Restoring serial divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module cfl_div
    import cfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [DNW-1:0] r_q;
    logic [W:0]     r_r;
    logic [W-1:0]   r_d;
    logic [6:0]     r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     n_sh;
    logic [W:0]     n_sub;

    always_comb begin
        n_sh  = {r_r[W-1:0], r_q[DNW-1]};
        n_sub = n_sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DNW);
                r_q    <= i_req.num;
                r_r    <= '0;
                r_d    <= i_req.den;
            end else if (r_busy) begin
                if (!n_sub[W]) begin
                    r_r <= n_sub;
                    r_q <= {r_q[DNW-2:0], 1'b1};
                end else begin
                    r_r <= n_sh;
                    r_q <= {r_q[DNW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r[W-1:0];
endmodule

FILE: rtl/cfl_timestep_controller.sv
// CFL time-step controller: picks the step size and keeps time and frame counts.
// Each word runs through up to three serial 32-bit multiplies and up to three
//   64-bit serial divides.
// Throughput: one word at a time; the next input can be taken the cycle after the result
//   is loaded into the output register.
// Reset (synchronous, active low) loads register defaults and clears all counters.
module cfl_timestep_controller
    import cfl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [W-1:0]    i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [W-1:0]    i_peak_speed,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [W-1:0]    o_step_size,
    output logic [W-1:0]    o_achieved_cfl,
    output logic [FW-1:0]   o_export_frame,
    output logic            o_quit_now,
    output logic [W-1:0]    o_steps_done,
    output logic [TW-1:0]   o_elapsed_time
);
    localparam logic [W-1:0]  ALL32 = '1;
    localparam logic [FW-1:0] ALL24 = '1;
    localparam logic [TW-1:0] ALL48 = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_CAP, S_LIM, S_CLAMP, S_FRAME, S_CFLMUL, S_CFLDIV, S_DONE
    } t_state;

    logic [W-1:0]  r_fixed, r_period_cfg, r_tcfl, r_min, r_cell;
    logic          r_sync, r_sq;
    logic [FW-1:0] r_flimit;

    logic [TW-1:0] r_time;
    logic [W-1:0]  r_rem;
    logic [FW-1:0] r_fcount;
    logic [W-1:0]  r_scount;
    logic          r_export;

    t_state        r_st;
    logic [W-1:0]  r_speed, r_dx, r_dt, r_cap;
    logic [2*W-1:0] r_cfldx;
    logic          r_wait;

    logic          r_ovalid;
    logic [W-1:0]  r_o_step, r_o_cfl, r_o_steps;
    logic [FW-1:0] r_o_exp;
    logic          r_o_quit;
    logic [TW-1:0] r_o_time;

    logic          n_mstart;
    logic [W-1:0]  n_ma, n_mb;
    logic          w_mdone;
    logic [2*W-1:0] w_prod;
    t_div_req      n_dreq;
    t_div_rsp      w_drsp;

    logic [W-1:0]  w_period;
    logic [W:0]    w_total;
    logic [W-1:0]  w_maxdt, w_lim, w_dtc, w_gap, w_dts;

    cfl_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_mstart),
        .i_a(n_ma), .i_b(n_mb), .o_done(w_mdone), .o_prod(w_prod)
    );
    cfl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_dreq), .o_rsp(w_drsp));

    function automatic logic [W-1:0] sat32(input logic [2*W-1:0] v);
        return (v[2*W-1:W] != '0) ? ALL32 : v[W-1:0];
    endfunction

    function automatic logic [FW-1:0] addf(input logic [FW-1:0] f,
                                            input logic [2*W-1:0] n);
        logic [2*W:0] s;
        s = {1'b0, n} + {{(2*W-FW+1){1'b0}}, f};
        return (s[2*W:FW] != '0) ? ALL24 : s[FW-1:0];
    endfunction

    assign w_period = (r_period_cfg == '0) ? {{(W-1){1'b0}}, 1'b1} : r_period_cfg;
    assign w_total  = {1'b0, r_rem} + {1'b0, r_dt};
    assign w_maxdt  = ((r_cap < w_period) ? r_cap : w_period) < r_min ? r_min
                    : ((r_cap < w_period) ? r_cap : w_period);
    assign w_gap    = (r_rem < w_period) ? (w_period - r_rem) : '0;
    assign w_dts    = (w_gap < r_min) ? r_min : w_gap;
    // lim = floor(cfl_dx / speed) >> (T-S), quotient of full cfl_dx
    assign w_lim    = sat32({{(TIME_FRAC_BITS-SPEED_FRAC_BITS){1'b0}},
                         w_drsp.quot[2*W-1:TIME_FRAC_BITS-SPEED_FRAC_BITS]});
    assign w_dtc    = ((w_lim < w_maxdt) ? w_lim : w_maxdt) < r_min ? r_min
                    : ((w_lim < w_maxdt) ? w_lim : w_maxdt);

    assign o_ready = (r_st == S_IDLE);

    always_comb begin
        n_mstart = 1'b0;
        n_ma     = '0;
        n_mb     = '0;
        n_dreq   = '0;
        if (!r_wait) begin
            unique case (r_st)
                S_SQ:     begin n_mstart = 1'b1; n_ma = r_cell; n_mb = r_cell; end
                S_CAP:    begin n_mstart = 1'b1; n_ma = r_tcfl; n_mb = r_dx; end
                S_LIM:    begin n_dreq.start = 1'b1; n_dreq.num = r_cfldx;
                                n_dreq.den = r_speed; end
                S_FRAME:  begin n_dreq.start = 1'b1;
                                n_dreq.num = {{(W-1){1'b0}}, w_total};
                                n_dreq.den = w_period; end
                S_CFLMUL: begin n_mstart = 1'b1; n_ma = r_dt; n_mb = r_speed; end
                S_CFLDIV: begin n_dreq.start = 1'b1;
                                n_dreq.num = w_prod << (TIME_FRAC_BITS-SPEED_FRAC_BITS);
                                n_dreq.den = r_cell; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed <= '0; r_period_cfg <= 32'd139810; r_tcfl <= 32'd33554432;
            r_min <= 32'd14; r_cell <= 32'd131072; r_sync <= 1'b0; r_sq <= 1'b0;
            r_flimit <= 24'd600;
            r_time <= '0; r_rem <= '0; r_fcount <= '0; r_scount <= '0; r_export <= 1'b0;
            r_st <= S_IDLE; r_wait <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIXED_STEP:   r_fixed      <= i_cfg_data;
                    CFG_FRAME_PERIOD: r_period_cfg <= i_cfg_data;
                    CFG_TARGET_CFL:   r_tcfl       <= i_cfg_data;
                    CFG_MIN_STEP:     r_min        <= i_cfg_data;
                    CFG_CELL_SIZE:    r_cell       <= i_cfg_data;
                    CFG_SYNC_FRAMES:  r_sync       <= i_cfg_data[0];
                    CFG_SQUARED_SP:   r_sq         <= i_cfg_data[0];
                    CFG_FRAME_LIMIT:  r_flimit     <= i_cfg_data[FW-1:0];
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            // launch a unit once, then hold until it reports done
            if (n_mstart || n_dreq.start) r_wait <= 1'b1;
            unique case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_speed <= i_peak_speed;
                    r_dx    <= r_cell;
                    if (r_fixed != '0) begin
                        r_dt <= r_fixed; r_st <= S_FRAME;
                    end else if (i_peak_speed == '0) begin
                        r_dt <= r_min; r_st <= S_CLAMP;
                    end else begin
                        r_st <= r_sq ? S_SQ : S_CAP;
                    end
                end
                S_SQ: if (w_mdone) begin
                    r_wait <= 1'b0;
                    r_dx   <= sat32(w_prod >> TIME_FRAC_BITS);
                    r_st   <= S_CAP;
                end
                S_CAP: if (w_mdone) begin
                    r_wait  <= 1'b0;
                    r_cfldx <= w_prod;
                    r_cap   <= sat32(w_prod >> TIME_FRAC_BITS);
                    r_st    <= S_LIM;
                end
                S_LIM: if (w_drsp.done) begin
                    r_wait <= 1'b0;
                    r_dt   <= w_dtc;
                    r_st   <= S_CLAMP;
                end
                S_CLAMP: begin
                    // adaptive frame accounting; sync cut adds exactly one frame
                    if (w_total >= {1'b0, w_period}) begin
                        r_export <= 1'b1;
                        if (r_sync) begin
                            r_dt     <= w_dts;
                            r_fcount <= addf(r_fcount, 64'd1);
                            r_st     <= S_FRAME;
                        end else begin
                            r_st <= S_FRAME;
                        end
                    end else begin
                        r_export <= 1'b0;
                        r_rem    <= w_total[W-1:0];
                        r_st     <= S_CFLMUL;
                    end
                end
                S_FRAME: if (w_drsp.done) begin
                    r_wait <= 1'b0;
                    r_rem  <= w_drsp.rem;
                    if (r_fixed != '0) begin
                        r_export <= (w_total >= {1'b0, w_period});
                        r_fcount <= addf(r_fcount, w_drsp.quot);
                    end else if (!r_sync) begin
                        r_fcount <= addf(r_fcount, w_drsp.quot);
                    end
                    r_st <= S_CFLMUL;
                end
                S_CFLMUL: if (w_mdone) begin
                    r_wait <= 1'b0;
                    r_st   <= S_CFLDIV;
                end
                S_CFLDIV: if (w_drsp.done) begin
                    r_wait <= 1'b0;
                    // a product that overflows the scaled dividend always saturates
                    if (r_cell == '0 ||
                        w_prod[2*W-1:2*W-(TIME_FRAC_BITS-SPEED_FRAC_BITS)] != '0)
                        r_o_cfl <= ALL32;
                    else r_o_cfl <= sat32(w_drsp.quot);
                    r_st <= S_DONE;
                end
                S_DONE: if (!r_ovalid || i_ready) begin
                    logic [TW:0] t;
                    t = {1'b0, r_time} + {{(TW-W+1){1'b0}}, r_dt};
                    r_time   <= t[TW] ? ALL48 : t[TW-1:0];
                    r_o_time <= t[TW] ? ALL48 : t[TW-1:0];
                    r_scount  <= (r_scount == ALL32) ? r_scount : r_scount + 32'd1;
                    r_o_steps <= (r_scount == ALL32) ? r_scount : r_scount + 32'd1;
                    r_o_step  <= r_dt;
                    r_o_exp   <= r_export ? r_fcount : '0;
                    r_o_quit  <= (r_flimit != '0) && (r_fcount >= r_flimit);
                    r_ovalid  <= 1'b1;
                    r_st      <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_step_size    = r_o_step;
    assign o_achieved_cfl = r_o_cfl;
    assign o_export_frame = r_o_exp;
    assign o_quit_now     = r_o_quit;
    assign o_steps_done   = r_o_steps;
    assign o_elapsed_time = r_o_time;
endmodule
